>>> design/stoi_pkg.sv
package stoi_pkg;

   // fixed result field widths
   localparam int ValueBits  = 32;
   localparam int OffsetBits = 16;
   localparam logic [OffsetBits-1:0] OffsetMax = '1;

   // configuration register index (taken from paddr[2])
   localparam logic CsrBaseSelect = 1'b0;

   // character codes
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7a;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5a;
   localparam logic [7:0] CharLowerX = 8'h78;
   localparam logic [7:0] CharUpperX = 8'h58;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharMinus  = 8'h2d;
   localparam logic [7:0] CharPlus   = 8'h2b;

   // radix codes
   localparam logic [5:0] RadixAuto = 6'd0;
   localparam logic [5:0] RadixOct  = 6'd8;
   localparam logic [5:0] RadixDec  = 6'd10;
   localparam logic [5:0] RadixHex  = 6'd16;

   // digit value that no radix accepts
   localparam logic [6:0] NoDigit = 7'd127;

   // one finished parse, from the engine to the result register
   typedef struct packed {
      logic                  hit;
      logic [ValueBits-1:0]  value;
      logic [OffsetBits-1:0] end_offset;
   } result_type;

   // digit value of a character, or NoDigit
   function automatic logic [6:0] digit_of(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (c >= CharZero && c <= CharNine) begin
            diff = c - CharZero;
         end else if (c >= CharLowerA && c <= CharLowerZ) begin
            diff = c - CharLowerA + 8'd10;
         end else if (c >= CharUpperA && c <= CharUpperZ) begin
            diff = c - CharUpperA + 8'd10;
         end else begin
            diff = {1'b0, NoDigit};
         end
         digit_of = diff[6:0];
      end
   endfunction

endpackage

>>> design/stoi_engine.sv
module stoi_engine #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          ch,
   input  logic                first,
   input  logic [5:0]          base_select,
   output stoi_pkg::result_type result
);
   import stoi_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_START,
      PH_ZERO,
      PH_HEXPFX,
      PH_DIGITS
   } phase_type;

   phase_type                  phase_ff, phase_in, ph;
   logic [VALUE_WIDTH-1:0]     acc_ff, acc_in, acc, acc_op, acc_next, neg_val;
   logic                       neg_ff, neg_in, neg;
   logic [5:0]                 base_ff, base_in, ab, ab_t;
   logic [OffsetBits-1:0]      cons_ff, cons_in, cons, cons_inc, stop;
   logic                       do_start, take, fresh, accept;
   logic [6:0]                 dig;
   logic [VALUE_WIDTH+5:0]     prod;
   logic [VALUE_WIDTH+31:0]    wide;

   // state seen by this character, after a possible restart
   assign ph       = first ? PH_LEAD : phase_ff;
   assign acc      = first ? '0 : acc_ff;
   assign neg      = first ? 1'b0 : neg_ff;
   assign ab       = first ? base_select : base_ff;
   assign cons     = first ? '0 : cons_ff;
   assign cons_inc = (cons != OffsetMax) ? cons + 1'b1 : cons;
   assign dig      = digit_of(ch);

   // per-character decision
   always_comb begin
      phase_in = ph;
      acc_in   = acc;
      neg_in   = neg;
      cons_in  = cons;
      ab_t     = ab;
      do_start = 1'b0;
      take     = 1'b0;
      fresh    = 1'b0;
      stop     = '0;
      unique case (ph)
         PH_LEAD: begin
            if (ch == CharSpace || ch == CharTab) begin
               cons_in = cons_inc;
            end else if (ch == CharMinus) begin
               neg_in   = 1'b1;
               cons_in  = cons_inc;
               phase_in = PH_START;
            end else if (ch == CharPlus) begin
               cons_in  = cons_inc;
               phase_in = PH_START;
            end else begin
               do_start = 1'b1;
            end
         end
         PH_START: begin
            do_start = 1'b1;
         end
         PH_ZERO: begin
            if (ch == CharLowerX || ch == CharUpperX) begin
               ab_t     = RadixHex;
               cons_in  = cons_inc;
               phase_in = PH_HEXPFX;
            end else begin
               ab_t = (ab == RadixAuto) ? RadixOct : ab;
               take = 1'b1;
               stop = cons;
            end
         end
         PH_HEXPFX: begin
            take  = 1'b1;
            fresh = 1'b1;
            stop  = (cons != '0) ? cons - 1'b1 : '0;
         end
         PH_DIGITS: begin
            take = 1'b1;
            stop = cons;
         end
         default: begin
         end
      endcase
      // first character past blanks and sign
      if (do_start) begin
         if (ch == CharZero && (ab == RadixAuto || ab == RadixHex)) begin
            acc_in   = '0;
            cons_in  = cons_inc;
            phase_in = PH_ZERO;
         end else begin
            ab_t  = (ab == RadixAuto) ? RadixDec : ab;
            take  = 1'b1;
            fresh = 1'b1;
            stop  = '0;
         end
      end
   end

   // digit multiply-add
   assign acc_op   = fresh ? '0 : acc;
   assign prod     = {6'b0, acc_op} * {{VALUE_WIDTH{1'b0}}, ab_t};
   assign acc_next = prod[VALUE_WIDTH-1:0] + {{(VALUE_WIDTH-6){1'b0}}, dig[5:0]};
   assign accept   = dig < {1'b0, ab_t};

   // signed result, sign-extended then cut to the port width
   assign neg_val = neg ? (~acc_op + 1'b1) : acc_op;
   assign wide    = {{32{neg_val[VALUE_WIDTH-1]}}, neg_val};

   always_comb begin
      result.hit        = take && !accept;
      result.value      = wide[ValueBits-1:0];
      result.end_offset = stop;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         cons_ff  <= '0;
      end else if (step) begin
         neg_ff  <= neg_in;
         base_ff <= ab_t;
         if (take && accept) begin
            acc_ff   <= acc_next;
            cons_ff  <= cons_inc;
            phase_ff <= PH_DIGITS;
         end else if (take) begin
            acc_ff   <= acc_in;
            cons_ff  <= cons_in;
            phase_ff <= PH_IDLE;
         end else begin
            acc_ff   <= acc_in;
            cons_ff  <= cons_in;
            phase_ff <= phase_in;
         end
      end
   end

endmodule

>>> design/string_to_integer_parser_core.sv
// Parses a signed integer from a character stream in the manner of strtol. Each request
// carries one byte in req_tdata and a first-of-string flag in req_tuser; one byte is taken
// per clock cycle unless the response side stalls; the result passes through the input
// register, the combinational parse step (one multiply-add by the 6-bit radix) and the
// result register. A string yields exactly one response, carrying the value and the count
// of bytes consumed, when the first byte that is not a digit of the radix (NUL included)
// arrives; bytes after that are ignored until the next first-flagged byte. The radix
// register (offset 0) is sampled on each first byte: 0 detects hex, octal or decimal from
// the prefix. Program it only while no string is in flight.
module string_to_integer_parser_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [0:0]  req_tuser,   // [0] first
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] value, [47:32] end_offset
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import stoi_pkg::*;

   logic       base_hit;
   logic [5:0] base_sel_ff;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_ch_ff;
   logic       s1_first_ff;
   logic       advance, step;
   result_type result;
   logic       out_valid_ff;
   logic [ValueBits-1:0]  out_value_ff;
   logic [OffsetBits-1:0] out_offset_ff;

   // register access
   assign csr_pready = 1'b1;
   assign base_hit   = (csr_paddr[2] == CsrBaseSelect);
   assign csr_prdata = base_hit ? {26'b0, base_sel_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_sel_ff <= RadixAuto;
      end else if (csr_psel && csr_penable && csr_pwrite && base_hit) begin
         base_sel_ff <= csr_pwdata[5:0];
      end
   end

   // flow control: result register frees when empty or taken
   assign advance     = !out_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || advance;
   assign step        = s1_valid_ff && advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_ch_ff    <= req_tdata;
         s1_first_ff <= req_tuser[0];
      end
   end

   stoi_engine #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .ch         (s1_ch_ff),
      .first      (s1_first_ff),
      .base_select(base_sel_ff),
      .result     (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step && result.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff  <= result.value;
         out_offset_ff <= result.end_offset;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_offset_ff, out_value_ff};

   // held request stays put while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ch_ff))
      else $error("input register changed while stalled");

   // back pressure only when both registers are full
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && out_valid_ff)
      else $error("request refused with room available");

   // nothing consumed means nothing parsed
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47:32] == 16'd0 |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero value with zero end offset");

endmodule

>>> tb/string_to_integer_parser_checker.sv
module string_to_integer_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [0:0]  req_tuser,   // [0] first
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [31:0] value, [47:32] end_offset
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   input  logic        drain_done,
   output int          error_count,
   output int          pending_count,
   output int          result_count
);
   import stoi_pkg::*;

   typedef enum logic [2:0] {
      ScanIdle,
      ScanLead,
      ScanSign,
      ScanZero,
      ScanHexPrefix,
      ScanDigits
   } scan_phase_type;

   typedef struct packed {
      logic [ValueBits-1:0]  value;
      logic [OffsetBits-1:0] end_offset;
   } parsed_number_type;

   parsed_number_type expected_numbers[$];

   // shadow of the radix register and of the parse state
   logic [5:0]            radix_reg;
   scan_phase_type        scan_phase;
   logic [ValueBits-1:0]  accum;
   logic                  negative;
   logic [5:0]            radix;
   logic [OffsetBits-1:0] consumed;
   bit                    leftover_reported;

   parsed_number_type     want;
   logic [ValueBits-1:0]  got_value;
   logic [OffsetBits-1:0] got_offset;

   // digit value of a byte in any radix up to 36
   function automatic logic [6:0] char_value(input logic [7:0] c);
      logic [7:0] t;
      begin
         if (c >= CharZero && c <= CharNine) begin
            t = c - CharZero;
         end else if (c >= CharLowerA && c <= CharLowerZ) begin
            t = c - CharLowerA + 8'd10;
         end else if (c >= CharUpperA && c <= CharUpperZ) begin
            t = c - CharUpperA + 8'd10;
         end else begin
            return NoDigit;
         end
         return t[6:0];
      end
   endfunction

   task automatic count_byte();
      if (consumed != OffsetMax) begin
         consumed = consumed + 1'b1;
      end
   endtask

   // finished parse: apply sign and queue the expected response
   task automatic finish_number(input logic [ValueBits-1:0] magnitude,
                                input logic [OffsetBits-1:0] offset);
      parsed_number_type r;
      r.value      = negative ? (~magnitude + 1'b1) : magnitude;
      r.end_offset = offset;
      expected_numbers.push_back(r);
      scan_phase = ScanIdle;
   endtask

   // accumulate one digit, or stop on a byte outside the radix
   task automatic take_digit(input logic [7:0] c, input bit fresh,
                             input logic [OffsetBits-1:0] stop_offset);
      logic [6:0]           d;
      logic [63:0]          prod;
      logic [ValueBits-1:0] start_acc;
      d         = char_value(c);
      start_acc = fresh ? '0 : accum;
      if (d != NoDigit && d < {1'b0, radix}) begin
         prod       = 64'(start_acc) * 64'(radix) + 64'(d);
         accum      = prod[ValueBits-1:0];
         count_byte();
         scan_phase = ScanDigits;
      end else begin
         finish_number(start_acc, stop_offset);
      end
   endtask

   // first byte after blanks and sign: possible zero prefix
   task automatic start_number(input logic [7:0] c);
      if (c == CharZero && (radix == RadixAuto || radix == RadixHex)) begin
         accum      = '0;
         count_byte();
         scan_phase = ScanZero;
      end else begin
         if (radix == RadixAuto) begin
            radix = RadixDec;
         end
         take_digit(c, 1'b1, '0);
      end
   endtask

   // one accepted request through the parse state
   task automatic parse_byte(input logic [7:0] c, input logic first);
      if (first) begin
         scan_phase = ScanLead;
         accum      = '0;
         negative   = 1'b0;
         consumed   = '0;
         radix      = radix_reg;
      end
      case (scan_phase)
         ScanLead: begin
            if (c == CharSpace || c == CharTab) begin
               count_byte();
            end else if (c == CharMinus) begin
               negative   = 1'b1;
               count_byte();
               scan_phase = ScanSign;
            end else if (c == CharPlus) begin
               count_byte();
               scan_phase = ScanSign;
            end else begin
               start_number(c);
            end
         end
         ScanSign: begin
            start_number(c);
         end
         ScanZero: begin
            if (c == CharLowerX || c == CharUpperX) begin
               radix      = RadixHex;
               count_byte();
               scan_phase = ScanHexPrefix;
            end else begin
               if (radix == RadixAuto) begin
                  radix = RadixOct;
               end
               take_digit(c, 1'b0, consumed);
            end
         end
         ScanHexPrefix: begin
            take_digit(c, 1'b1, (consumed != '0) ? consumed - 1'b1 : '0);
         end
         ScanDigits: begin
            take_digit(c, 1'b0, consumed);
         end
         default: begin
         end
      endcase
   endtask

   // watch all three ports at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         expected_numbers.delete();
         radix_reg         = RadixAuto;
         scan_phase        = ScanIdle;
         accum             = '0;
         negative          = 1'b0;
         radix             = RadixAuto;
         consumed          = '0;
         leftover_reported = 1'b0;
         error_count       = 0;
         result_count      = 0;
      end else begin
         // register writes and read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CsrBaseSelect) begin
                  radix_reg = csr_pwdata[5:0];
               end
            end else if (csr_prdata !== {26'd0, radix_reg}) begin
               $error("base_select mismatch: expected %0d, actual %0d",
                      radix_reg, csr_prdata);
               error_count++;
            end
         end

         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tuser[0]);
         end

         // responses against the oldest expected number
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            got_value  = rsp_tdata[31:0];
            got_offset = rsp_tdata[47:32];
            if (expected_numbers.size() == 0) begin
               $error("unexpected response: value %0d, end_offset %0d",
                      $signed(got_value), got_offset);
               error_count++;
            end else begin
               want = expected_numbers.pop_front();
               if (got_value !== want.value) begin
                  $error("value mismatch: expected %0d, actual %0d",
                         $signed(want.value), $signed(got_value));
                  error_count++;
               end
               if (got_offset !== want.end_offset) begin
                  $error("end_offset mismatch: expected %0d, actual %0d",
                         want.end_offset, got_offset);
                  error_count++;
               end
            end
         end

         // numbers still owed once the run has drained
         if (drain_done && !leftover_reported) begin
            leftover_reported = 1'b1;
            if (expected_numbers.size() != 0) begin
               $error("%0d expected responses never arrived", expected_numbers.size());
               error_count += expected_numbers.size();
            end
         end
      end
      pending_count = expected_numbers.size();
   end

endmodule

>>> tb/tb_string_to_integer_parser_core.sv
module tb_string_to_integer_parser_core;
   import stoi_pkg::*;

   localparam logic [2:0] BaseSelectAddr = {CsrBaseSelect, 2'b00};
   localparam int StallLimit  = 5000;
   localparam int HoldCycles  = 400;
   localparam int SettleTicks = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] ch
   logic [0:0]  req_tuser = '0;   // [0] first
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [31:0] value, [47:32] end_offset
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bit          drain_done = 1'b0;
   bit          hold_pending = 1'b0;
   int          idle_pct = 30;
   int          stall_cycles = 0;
   int          sent_count = 0;
   int          radix_changes = 0;
   logic [5:0]  cur_radix = RadixAuto;
   logic [7:0]  text_bytes[$];

   int          error_count;
   int          pending_count;
   int          result_count;

   always #10 clock = ~clock;

   string_to_integer_parser_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   string_to_integer_parser_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .drain_done    (drain_done),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // response side: random back-pressure, plus one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // one request; entered and left at a falling edge
   task automatic send_char(input logic [7:0] c, input logic first);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_text(input string s, input bit nul_end);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == 0);
      end
      if (nul_end) begin
         send_char(8'h00, s.len() == 0);
      end
   endtask

   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // close any open string, drain, then program and read back the radix
   task automatic set_radix(input logic [5:0] r);
      send_char(8'h00, 1'b0);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SettleTicks) @(negedge clock);
      csr_access(1'b1, BaseSelectAddr, {26'd0, r});
      csr_access(1'b0, BaseSelectAddr, '0);
      cur_radix = r;
      radix_changes++;
   endtask

   function automatic logic [7:0] digit_char(input int eff);
      int lim;
      int d;
      lim = (eff > 36) ? 36 : ((eff < 1) ? 1 : eff);
      d   = $urandom_range(lim - 1);
      if (d < 10) begin
         return CharZero + 8'(d);
      end
      return ($urandom_range(1) ? CharLowerA : CharUpperA) + 8'(d - 10);
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(7))
         0: return CharSpace;
         1: return CharTab;
         2: return CharMinus;
         3: return CharPlus;
         4: return CharZero;
         5: return $urandom_range(1) ? CharLowerX : CharUpperX;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly well-formed numbers with random content, some noise
   task automatic make_string();
      int eff;
      int ndig;
      text_bytes.delete();
      if ($urandom_range(99) < 80) begin
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) text_bytes.push_back($urandom_range(1) ? CharSpace : CharTab);
         end
         case ($urandom_range(3))
            0: text_bytes.push_back(CharMinus);
            1: text_bytes.push_back(CharPlus);
            default: begin
            end
         endcase
         eff = cur_radix;
         if (cur_radix == RadixAuto) begin
            case ($urandom_range(2))
               0: begin
                  text_bytes.push_back(CharZero);
                  text_bytes.push_back($urandom_range(1) ? CharLowerX : CharUpperX);
                  eff = RadixHex;
               end
               1: begin
                  text_bytes.push_back(CharZero);
                  eff = RadixOct;
               end
               default: eff = RadixDec;
            endcase
         end else if (cur_radix == RadixHex && $urandom_range(1)) begin
            text_bytes.push_back(CharZero);
            text_bytes.push_back($urandom_range(1) ? CharLowerX : CharUpperX);
         end
         ndig = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
         repeat (ndig) text_bytes.push_back(digit_char(eff));
         if ($urandom_range(2) != 0) begin
            text_bytes.push_back(8'h00);
         end else begin
            text_bytes.push_back(8'($urandom_range(255)));
         end
         // trailing bytes, ignored once the number has ended
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(255)));
         end
      end else begin
         repeat ($urandom_range(1, 6)) text_bytes.push_back(noise_char());
      end
   endtask

   task automatic random_strings(input int n);
      int target;
      target = sent_count + n;
      while (sent_count < target) begin
         make_string();
         foreach (text_bytes[i]) begin
            send_char(text_bytes[i], i == 0);
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // prefix detection: sign, hex, bare hex prefix, octal, blanks, no digits
      set_radix(RadixAuto);
      send_text("-12", 1'b1);
      send_text("0x1F", 1'b1);
      send_text("0xg", 1'b0);
      send_text("09", 1'b0);
      send_text(" \t+7 ", 1'b0);
      send_text("-", 1'b1);
      send_text("", 1'b1);
      send_char(8'h35, 1'b0);
      send_char(8'hff, 1'b1);
      // restart in the middle of a string
      send_text("12", 1'b0);
      send_text("34", 1'b1);
      random_strings(170);

      // hex with wrap and the most negative value
      set_radix(RadixHex);
      send_text("0XFFFFFFFF", 1'b1);
      send_text("-80000000", 1'b1);
      random_strings(150);

      // decimal overflow, with the receiver held off for a long stretch
      set_radix(RadixDec);
      send_text("99999999999", 1'b1);
      hold_pending = 1'b1;
      random_strings(150);

      // octal with no idling on either side
      set_radix(RadixOct);
      idle_pct = 0;
      random_strings(120);
      idle_pct = 30;

      set_radix(6'd36);
      send_text("Zz", 1'b1);
      random_strings(120);

      set_radix(6'd2);
      random_strings(80);

      // odd radixes, used as given
      set_radix(6'd1);
      send_text("001", 1'b1);
      random_strings(40);

      set_radix(6'd63);
      send_text("zZ~", 1'b0);
      random_strings(60);

      set_radix(6'($urandom_range(63)));
      random_strings(100);

      set_radix(RadixAuto);
      random_strings(60);

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      drain_done = 1'b1;
      @(negedge clock);

      $display("covered %0d requests and %0d responses over %0d radix settings,",
               sent_count, result_count, radix_changes);
      $display("including prefixes, restarts, noise and a long response hold");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> string_to_integer_parser_core.f
design/stoi_pkg.sv
design/stoi_engine.sv
design/string_to_integer_parser_core.sv
tb/string_to_integer_parser_checker.sv
tb/tb_string_to_integer_parser_core.sv
